@@ rtl/pal_pkg.sv @@
package pal_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned PosW  = 7;
  localparam int unsigned ValW  = 32;
  localparam int unsigned StW   = 2;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned FillW = 7;

  localparam logic [OpW-1:0] OP_INSERT   = 2'd0;
  localparam logic [OpW-1:0] OP_DELETE   = 2'd1;
  localparam logic [OpW-1:0] OP_TRAVERSE = 2'd2;

  localparam logic [StW-1:0] ST_OK     = 2'd0;
  localparam logic [StW-1:0] ST_FULL   = 2'd1;
  localparam logic [StW-1:0] ST_BADPOS = 2'd2;
  localparam logic [StW-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]         opcode;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] new_value;
  } pal_in_t;

  typedef struct packed {
    logic [StW-1:0]         status;
    logic signed [ValW-1:0] entry_value;
    logic [IdxW-1:0]        entry_index;
    logic [FillW-1:0]       fill_count;
    logic                   last;
  } pal_out_t;

  // controller to datapath
  typedef struct packed {
    logic            do_ins;
    logic            do_del;
    logic            do_rot;
    logic            load_out;
    logic            sel_cell;
    logic [StW-1:0]  status;
    logic [IdxW-1:0] index;
    logic            last;
  } pal_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FillW-1:0] count;
  } pal_stat_t;

endpackage

@@ rtl/positional_array_list_unit.sv @@
// Ordered list of up to DEPTH signed 32-bit values with insert, delete and
// traverse operations.
// Channels: the input channel (in_valid_i/in_ready_o/in_i) carries one
// command per transfer; the output channel (out_valid_o/out_ready_i/out_o)
// carries results from a registered output stage.
// Insert and delete shift every cell at once in the accept cycle and give
// one result from the register in the next cycle; an insert into a full
// list, or a delete or insert at a bad position, answers with an error
// status and leaves the list alone. Opcode 3 is dropped without a result.
// A traverse streams one entry per cycle while the receiver is ready, one
// per held entry: the cells rotate by one on each step, emitting cell zero,
// so the list is back in place after the last entry. An empty list gives
// one result, status empty. The single result register means that a new
// command is taken only once the last result of the previous one is out.
// Reset clears the fill count and the controller; cell contents are left
// as they are and are never read before being written.
// A stalled receiver holds the result register and pauses any traverse.
module positional_array_list_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pal_pkg::pal_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pal_pkg::pal_out_t out_o
);

  pal_pkg::pal_cmd_t  cmd;
  pal_pkg::pal_stat_t stat;

  // sequencing: accept, decode, stream the traverse
  pal_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // cells, fill count and result register
  pal_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .out_o (out_o)
  );

endmodule

@@ rtl/pal_dp.sv @@
module pal_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pal_pkg::pal_in_t   in_i,
  input  pal_pkg::pal_cmd_t  cmd_i,
  output pal_pkg::pal_stat_t stat_o,
  output pal_pkg::pal_out_t  out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]              count_q, count_d;
  logic [pal_pkg::FillW-1:0]    cnt_ext;
  logic [pal_pkg::PosW-1:0]     pos;
  logic signed [pal_pkg::ValW-1:0] cells_q [DEPTH];
  pal_pkg::pal_out_t            out_q;

  assign pos     = in_i.position;
  assign cnt_ext = pal_pkg::FillW'(count_q);

  always_comb begin
    count_d = count_q;
    if (cmd_i.do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.do_del) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Each cell sees only its neighbors and cell zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [pal_pkg::ValW-1:0] prev_w, next_w, cell_d;
    logic [pal_pkg::PosW-1:0]        at;

    assign at = pal_pkg::PosW'(i);

    if (i > 0) begin : g_prev
      assign prev_w = cells_q[i-1];
    end else begin : g_noprev
      assign prev_w = '0;
    end

    if (i < DEPTH - 1) begin : g_next
      assign next_w = cells_q[i+1];
    end else begin : g_nonext
      assign next_w = '0;
    end

    always_comb begin
      cell_d = cells_q[i];
      if (cmd_i.do_ins) begin
        if (at == pos) begin
          cell_d = in_i.new_value;
        end else if (at > pos && at <= cnt_ext) begin
          cell_d = prev_w;
        end
      end else if (cmd_i.do_del) begin
        if (at >= pos && at + 7'd1 < cnt_ext) begin
          cell_d = next_w;
        end
      end else if (cmd_i.do_rot) begin
        if (at + 7'd1 < cnt_ext) begin
          cell_d = next_w;
        end else if (at + 7'd1 == cnt_ext) begin
          cell_d = cells_q[0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cells_q[i] <= cell_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status      <= cmd_i.status;
      out_q.entry_value <= cmd_i.sel_cell ? cells_q[0] : '0;
      out_q.entry_index <= cmd_i.index;
      out_q.fill_count  <= pal_pkg::FillW'(count_d);
      out_q.last        <= cmd_i.last;
    end
  end

  assign stat_o.count = cnt_ext;
  assign out_o        = out_q;

endmodule

@@ rtl/pal_ctrl.sv @@
module pal_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pal_pkg::pal_in_t   in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pal_pkg::pal_stat_t stat_i,
  output pal_pkg::pal_cmd_t  cmd_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [0:0]  S_IDLE = 1'b0;
  localparam logic [0:0]  S_OUT  = 1'b1;
  localparam logic [pal_pkg::FillW-1:0] Full = pal_pkg::FillW'(DEPTH);

  logic [0:0]                state_q, state_d;
  logic [IW-1:0]             idx_q, idx_d;
  logic                      last_q, last_d;
  logic [pal_pkg::FillW-1:0] cnt;
  logic [pal_pkg::FillW-1:0] idx_next;

  assign cnt      = stat_i.count;
  assign idx_next = pal_pkg::FillW'(idx_q) + 7'd1;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    idx_d   = idx_q;
    last_d  = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_i.opcode)
            pal_pkg::OP_INSERT: begin
              cmd_o.load_out = 1'b1;
              cmd_o.last     = 1'b1;
              if (cnt == Full) begin
                cmd_o.status = pal_pkg::ST_FULL;
              end else if (in_i.position > cnt) begin
                cmd_o.status = pal_pkg::ST_BADPOS;
              end else begin
                cmd_o.status = pal_pkg::ST_OK;
                cmd_o.do_ins = 1'b1;
              end
            end
            pal_pkg::OP_DELETE: begin
              cmd_o.load_out = 1'b1;
              cmd_o.last     = 1'b1;
              if (in_i.position >= cnt) begin
                cmd_o.status = pal_pkg::ST_BADPOS;
              end else begin
                cmd_o.status = pal_pkg::ST_OK;
                cmd_o.do_del = 1'b1;
              end
            end
            pal_pkg::OP_TRAVERSE: begin
              cmd_o.load_out = 1'b1;
              if (cnt == '0) begin
                cmd_o.status = pal_pkg::ST_EMPTY;
                cmd_o.last   = 1'b1;
              end else begin
                cmd_o.status   = pal_pkg::ST_OK;
                cmd_o.sel_cell = 1'b1;
                cmd_o.do_rot   = 1'b1;
                cmd_o.last     = (cnt == 7'd1);
                idx_d          = IW'(1);
              end
            end
            default: ;
          endcase
          if (cmd_o.load_out) begin
            state_d = S_OUT;
            last_d  = cmd_o.last;
          end
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.load_out = 1'b1;
            cmd_o.status   = pal_pkg::ST_OK;
            cmd_o.sel_cell = 1'b1;
            cmd_o.do_rot   = 1'b1;
            cmd_o.index    = pal_pkg::IdxW'(idx_q);
            cmd_o.last     = (idx_next == cnt);
            idx_d          = idx_q + IW'(1);
            last_d         = cmd_o.last;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  // Clock period in ns and the list size the block is built with.
  localparam int ClkPeriod = 4;
  localparam int ListDepth = 64;
  // The opcode the block must drop without a result.
  localparam logic [pal_pkg::OpW-1:0] OpUnused = 2'd3;
  // Length of the one long hold on the result channel, to back the block up.
  localparam int LongHold = 300;
  // Start no more idle bursts once fewer than this many commands remain to be sent.
  localparam int CalmTail = 40;

  // One backlog entry: either a command or a marker that makes the sender
  // wait until every predicted result has come back.
  typedef struct {
    bit               pause;
    pal_pkg::pal_in_t cmd;
  } backlog_item_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  pal_pkg::pal_in_t  in_i        = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  pal_pkg::pal_out_t out_o;

  positional_array_list_unit #(
    .DEPTH(ListDepth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // Commands waiting to be sent, and results the list is predicted to give.
  backlog_item_t     cmd_backlog[$];
  pal_pkg::pal_out_t list_replies[$];

  // Predicted list contents and fill count.
  logic signed [pal_pkg::ValW-1:0] shadow_cells [ListDepth];
  int                              shadow_len = 0;

  // Fill count as the stimulus generator sees it, to aim positions.
  int gen_len = 0;

  bit in_xfer       = 1'b0;  // command transfer at the last rising edge
  int accepted_cmds = 0;
  int mismatches    = 0;

  // Idling stops for the final stretch of the run.
  function automatic bit calm();
    return (cmd_backlog.size() < CalmTail);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Apply one accepted command to the shadow list and queue up the
  // results it should give, in order.
  task automatic apply_list_op(input pal_pkg::pal_in_t cmd);
    pal_pkg::pal_out_t r;
    int                pos;
    int                i;
    r      = '0;
    r.last = 1'b1;
    pos    = int'(cmd.position);
    case (cmd.opcode)
      pal_pkg::OP_INSERT: begin
        // A full list is reported even when the position is also bad.
        if (shadow_len >= ListDepth) begin
          r.status = pal_pkg::ST_FULL;
        end else if (pos > shadow_len) begin
          r.status = pal_pkg::ST_BADPOS;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_cells[i] = shadow_cells[i - 1];
          shadow_cells[pos] = cmd.new_value;
          shadow_len++;
          r.status = pal_pkg::ST_OK;
        end
        r.fill_count = pal_pkg::FillW'(shadow_len);
        list_replies.push_back(r);
      end
      pal_pkg::OP_DELETE: begin
        if (pos >= shadow_len) begin
          r.status = pal_pkg::ST_BADPOS;
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i + 1];
          shadow_len--;
          r.status = pal_pkg::ST_OK;
        end
        r.fill_count = pal_pkg::FillW'(shadow_len);
        list_replies.push_back(r);
      end
      pal_pkg::OP_TRAVERSE: begin
        if (shadow_len == 0) begin
          r.status = pal_pkg::ST_EMPTY;
          list_replies.push_back(r);
        end else begin
          // One result per held entry, the last one flagged.
          for (i = 0; i < shadow_len; i++) begin
            r.status      = pal_pkg::ST_OK;
            r.entry_value = shadow_cells[i];
            r.entry_index = pal_pkg::IdxW'(i);
            r.fill_count  = pal_pkg::FillW'(shadow_len);
            r.last        = (i + 1 == shadow_len);
            list_replies.push_back(r);
          end
        end
      end
      default: begin
        // Unused opcode: no result, no change.
      end
    endcase
  endtask

  // Append a command to the backlog and track the fill count it leaves.
  task automatic queue_cmd(input logic [pal_pkg::OpW-1:0] op, input int pos,
                           input logic [pal_pkg::ValW-1:0] val);
    backlog_item_t item;
    item.pause          = 1'b0;
    item.cmd.opcode     = op;
    item.cmd.position   = pal_pkg::PosW'(pos);
    item.cmd.new_value  = val;
    cmd_backlog.push_back(item);
    if (op == pal_pkg::OP_INSERT && gen_len < ListDepth && pos <= gen_len) gen_len++;
    if (op == pal_pkg::OP_DELETE && pos < gen_len) gen_len--;
  endtask

  task automatic queue_pause();
    backlog_item_t item;
    item.pause = 1'b1;
    item.cmd   = '0;
    cmd_backlog.push_back(item);
  endtask

  // Pick a data word: mostly random, sometimes an extreme.
  function automatic logic [pal_pkg::ValW-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Sender: present the next command at the falling edge. Hold valid and
  // the payload steady until a transfer has been seen.
  always @(negedge clk_i) begin : feed
    backlog_item_t item;
    static int  send_gap     = 0;
    static int  phase_tick   = 0;
    static bit  send_idle_on = 1'b1;
    static bit  wait_drain   = 1'b0;
    // Re-pick at each wrap of phase_tick whether this side idles at all, so that
    // busy stretches with no gaps show up too.
    if (phase_tick == 0) send_idle_on = ($urandom_range(0, 3) != 0);
    phase_tick = (phase_tick + 1) % 64;
    if (rst_ni && !(in_valid_i && !in_xfer)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (wait_drain) begin
        // Hold off until every predicted result has been transferred.
        if (list_replies.size() == 0) wait_drain = 1'b0;
        in_valid_i <= 1'b0;
      end else if (cmd_backlog.size() != 0 && cmd_backlog[0].pause) begin
        item       = cmd_backlog.pop_front();
        wait_drain = 1'b1;
        in_valid_i <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        if (!calm() && send_idle_on && $urandom_range(0, 4) == 0) begin
          // Start an idle burst; this cycle is the first, and send_gap holds the rest.
          send_gap = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else begin
          item = cmd_backlog.pop_front();
          in_i       <= item.cmd;
          in_valid_i <= 1'b1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: drive ready at the falling edge. Once, well into the run,
  // drop ready for a long stretch so the block stalls its input.
  always @(negedge clk_i) begin : sink
    static int recv_gap     = 0;
    static int long_hold    = 0;
    static bit held_once    = 1'b0;
    static int phase_tick   = 0;
    static bit recv_idle_on = 1'b1;
    if (phase_tick == 0) recv_idle_on = ($urandom_range(0, 3) != 0);
    phase_tick = (phase_tick + 1) % 64;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold--;
      out_ready_i <= 1'b0;
    end else if (!held_once && accepted_cmds >= 150) begin
      held_once = 1'b1;
      long_hold = LongHold - 1;
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm() && recv_idle_on && $urandom_range(0, 4) == 0) begin
      recv_gap = $urandom_range(0, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: at the rising edge, predict from an accepted command first,
  // then check any result transfer against the oldest prediction.
  always @(posedge clk_i) begin : watch
    pal_pkg::pal_out_t want;
    in_xfer = rst_ni && in_valid_i && in_ready_o;
    if (in_xfer) begin
      apply_list_op(in_i);
      accepted_cmds++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (list_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_o);
        mismatches++;
      end else begin
        want = list_replies.pop_front();
        if (out_o.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_o.status);
          mismatches++;
        end
        if (out_o.entry_value !== want.entry_value) begin
          $display("%0t: entry_value expected %0d got %0d", $time, want.entry_value,
                   out_o.entry_value);
          mismatches++;
        end
        if (out_o.entry_index !== want.entry_index) begin
          $display("%0t: entry_index expected %0d got %0d", $time, want.entry_index,
                   out_o.entry_index);
          mismatches++;
        end
        if (out_o.fill_count !== want.fill_count) begin
          $display("%0t: fill_count expected %0d got %0d", $time, want.fill_count,
                   out_o.fill_count);
          mismatches++;
        end
        if (out_o.last !== want.last) begin
          $display("%0t: last expected %0d got %0d", $time, want.last, out_o.last);
          mismatches++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int  n;
    int  pick;
    bit  grow;
    // Directed part: empty-list cases, both ends and the middle, bad
    // positions at the boundary and at the top of the field, the unused
    // opcode, and deleting back down to empty.
    queue_cmd(pal_pkg::OP_TRAVERSE, 0, '0);
    queue_cmd(pal_pkg::OP_DELETE, 0, '0);
    queue_cmd(pal_pkg::OP_INSERT, 1, 32'h1234_5678);
    queue_cmd(pal_pkg::OP_INSERT, 127, 32'hDEAD_BEEF);
    queue_cmd(pal_pkg::OP_INSERT, 0, 32'h7FFF_FFFF);
    queue_cmd(pal_pkg::OP_INSERT, 0, 32'h8000_0000);
    queue_cmd(pal_pkg::OP_INSERT, 2, 32'hFFFF_FFFF);
    queue_cmd(pal_pkg::OP_INSERT, 1, 32'h0000_0000);
    queue_cmd(pal_pkg::OP_TRAVERSE, 127, 32'hFFFF_FFFF);
    queue_cmd(OpUnused, 127, 32'hFFFF_FFFF);
    queue_cmd(OpUnused, 0, 32'h0000_0000);
    queue_cmd(pal_pkg::OP_DELETE, 4, '0);
    queue_cmd(pal_pkg::OP_DELETE, 127, '0);
    queue_cmd(pal_pkg::OP_INSERT, 5, 32'h5555_5555);
    queue_cmd(pal_pkg::OP_DELETE, 1, '0);
    queue_cmd(pal_pkg::OP_TRAVERSE, 0, '0);
    queue_cmd(pal_pkg::OP_DELETE, 2, '0);
    queue_cmd(pal_pkg::OP_DELETE, 0, '0);
    queue_cmd(pal_pkg::OP_TRAVERSE, 0, '0);
    queue_cmd(pal_pkg::OP_DELETE, 0, '0);
    queue_cmd(pal_pkg::OP_TRAVERSE, 0, '0);
    queue_pause();

    // Random part: swing between filling and draining so the list hits
    // both full and empty, with traverses, bad positions and noise mixed in.
    grow = 1'b1;
    n    = 0;
    while (n < 360) begin
      pick = $urandom_range(0, 99);
      if (n == 200) queue_pause();
      if (pick < 8) begin
        queue_cmd(pal_pkg::OP_TRAVERSE, $urandom_range(0, 127), $urandom());
        n++;
      end else if (pick < 11) begin
        // Noise that the block drops; not counted.
        queue_cmd(OpUnused, $urandom_range(0, 127), $urandom());
      end else if (pick < 17) begin
        // Out-of-range positions.
        if ($urandom_range(0, 1) == 0 && gen_len < 127)
          queue_cmd(pal_pkg::OP_INSERT, $urandom_range(gen_len + 1, 127), pick_value());
        else
          queue_cmd(pal_pkg::OP_DELETE, $urandom_range(gen_len, 127), '0);
        n++;
      end else if (grow && gen_len == ListDepth) begin
        // Insert into a full list, any position; then maybe turn around.
        queue_cmd(pal_pkg::OP_INSERT, $urandom_range(0, 127), pick_value());
        if ($urandom_range(0, 2) == 0) grow = 1'b0;
        n++;
      end else begin
        if (!grow && gen_len == 0) grow = 1'b1;
        if ($urandom_range(0, 59) == 0) grow = !grow;
        if ((grow && gen_len < ListDepth && $urandom_range(0, 4) != 0) ||
            (gen_len == 0) || (!grow && $urandom_range(0, 4) == 0 &&
            gen_len < ListDepth))
          queue_cmd(pal_pkg::OP_INSERT, $urandom_range(0, gen_len), pick_value());
        else
          queue_cmd(pal_pkg::OP_DELETE, $urandom_range(0, gen_len - 1), '0);
        n++;
      end
    end

    // Release reset at a falling edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every command to go out, then for every result to drain.
    while (cmd_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (list_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && list_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #(ClkPeriod * 1_500_000);
    $display("FAILURE");
    $finish;
  end

endmodule
